FILE: sv/rtcs_pkg.sv
// Package for the real-time core selection block: item structs, the
// per-record qualification struct and the sizing constants.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package rtcs_pkg;

    // Number of cores the selection covers
    localparam int NUM_CORES = 8;

    // Capacity scale (1024) expressed as a shift
    localparam int CAP_SHIFT = 10;

    // Field widths
    localparam int CORE_W   = 3;
    localparam int LOAD_W   = 11;
    localparam int MARGIN_W = 12;
    localparam int LAT_W    = 16;
    localparam int UTIL_W   = LOAD_W + 1;
    localparam int PROD_W   = UTIL_W + MARGIN_W;

    // One core record
    typedef struct packed {
        logic [CORE_W-1:0]   core_index;
        logic                in_candidates;
        logic                eligible;
        logic                core_idle;
        logic                small_core;
        logic [LOAD_W-1:0]   core_load;
        logic [LOAD_W-1:0]   core_capacity;
        logic [MARGIN_W-1:0] margin_up;
        logic [LAT_W-1:0]    wake_latency;
        logic [LOAD_W-1:0]   task_load;
        logic [CORE_W-1:0]   previous_core;
        logic                last_record;
    } t_in_item;

    // One selection result
    typedef struct packed {
        logic              found;
        logic [CORE_W-1:0] target_core;
    } t_out_item;

    // Qualification of one record, computed ahead of the tracking stage
    typedef struct packed {
        logic              in_range;
        logic              qual;
        logic              prev_hit;
        logic [UTIL_W-1:0] util;
    } t_fit;

endpackage

FILE: sv/rtcs_fit.sv
// Capacity fit check for one core record: combined load, margin multiply
// and candidate tests. Depends on rtcs_pkg.
`timescale 1ns / 1ps

module rtcs_fit (
    input  rtcs_pkg::t_in_item i_item,
    output rtcs_pkg::t_fit     o_fit
);

    logic [rtcs_pkg::UTIL_W-1:0] util;
    logic [rtcs_pkg::PROD_W-1:0] prod;
    logic [rtcs_pkg::PROD_W-1:0] cap_scaled;
    logic                        fits;

    // Combined load times margin against scaled capacity
    always_comb begin
        util       = rtcs_pkg::UTIL_W'(i_item.core_load)
                   + rtcs_pkg::UTIL_W'(i_item.task_load);
        prod       = rtcs_pkg::PROD_W'(util) * rtcs_pkg::PROD_W'(i_item.margin_up);
        cap_scaled = rtcs_pkg::PROD_W'(i_item.core_capacity) << rtcs_pkg::CAP_SHIFT;
        fits       = (prod <= cap_scaled);
    end

    // Qualification flags for the tracking stage
    always_comb begin
        o_fit.in_range = (32'(i_item.core_index) < rtcs_pkg::NUM_CORES);
        o_fit.qual     = i_item.in_candidates && i_item.eligible && fits;
        o_fit.prev_hit = (i_item.core_index == i_item.previous_core)
                       && i_item.in_candidates && i_item.core_idle && i_item.small_core;
        o_fit.util     = util;
    end

endmodule

FILE: sv/rtcs_track.sv
// Running-best tracking for idle and busy cores, and the final target
// decision on the last record. Depends on rtcs_pkg.
`timescale 1ns / 1ps

module rtcs_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  rtcs_pkg::t_in_item  i_item,
    input  rtcs_pkg::t_fit      i_fit,
    input  logic                i_enable,
    output rtcs_pkg::t_out_item o_result
);

    logic                          r_idle_valid, n_idle_valid;
    logic [rtcs_pkg::CORE_W-1:0]   r_idle_core, n_idle_core;
    logic [rtcs_pkg::LOAD_W-1:0]   r_idle_cap, n_idle_cap;
    logic [rtcs_pkg::LAT_W-1:0]    r_idle_lat, n_idle_lat;
    logic                          r_idle_small, n_idle_small;
    logic                          r_busy_valid, n_busy_valid;
    logic [rtcs_pkg::CORE_W-1:0]   r_busy_core, n_busy_core;
    logic [rtcs_pkg::LOAD_W-1:0]   r_busy_cap, n_busy_cap;
    logic [rtcs_pkg::UTIL_W-1:0]   r_busy_load, n_busy_load;
    logic                          r_busy_small, n_busy_small;
    logic                          r_prev_hit, n_prev_hit;
    logic                          take;
    logic                          upd_idle;
    logic                          upd_busy;

    // Compare the record against the current bests
    always_comb begin
        take     = i_fit.in_range && i_fit.qual;
        upd_idle = take && i_item.core_idle
                 && (!r_idle_valid || (i_item.core_capacity < r_idle_cap)
                     || ((i_item.core_capacity == r_idle_cap)
                         && (i_item.wake_latency < r_idle_lat)));
        upd_busy = take && !i_item.core_idle
                 && (!r_busy_valid || (i_item.core_capacity < r_busy_cap)
                     || ((i_item.core_capacity == r_busy_cap)
                         && (i_fit.util < r_busy_load)));
    end

    // Next bests including this record
    always_comb begin
        n_prev_hit   = r_prev_hit || (i_fit.in_range && i_fit.prev_hit);
        n_idle_valid = r_idle_valid || upd_idle;
        n_idle_core  = upd_idle ? i_item.core_index    : r_idle_core;
        n_idle_cap   = upd_idle ? i_item.core_capacity : r_idle_cap;
        n_idle_lat   = upd_idle ? i_item.wake_latency  : r_idle_lat;
        n_idle_small = upd_idle ? i_item.small_core    : r_idle_small;
        n_busy_valid = r_busy_valid || upd_busy;
        n_busy_core  = upd_busy ? i_item.core_index    : r_busy_core;
        n_busy_cap   = upd_busy ? i_item.core_capacity : r_busy_cap;
        n_busy_load  = upd_busy ? i_fit.util           : r_busy_load;
        n_busy_small = upd_busy ? i_item.small_core    : r_busy_small;
    end

    // Pick the target by preference order
    always_comb begin
        o_result.found       = 1'b1;
        o_result.target_core = '0;
        priority if (n_prev_hit) begin
            o_result.target_core = i_item.previous_core;
        end else if (n_idle_valid && n_idle_small) begin
            o_result.target_core = n_idle_core;
        end else if (n_busy_valid && n_busy_small) begin
            o_result.target_core = n_busy_core;
        end else if (n_idle_valid) begin
            o_result.target_core = n_idle_core;
        end else if (n_busy_valid) begin
            o_result.target_core = n_busy_core;
        end else begin
            o_result.found = 1'b0;
        end
        if (!i_enable || !o_result.found) begin
            o_result.found       = 1'b0;
            o_result.target_core = '0;
        end
    end

    // Flags: advance per record, drop at the end of a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_valid <= 1'b0;
            r_busy_valid <= 1'b0;
            r_prev_hit   <= 1'b0;
        end else if (i_go) begin
            r_idle_valid <= n_idle_valid && !i_item.last_record;
            r_busy_valid <= n_busy_valid && !i_item.last_record;
            r_prev_hit   <= n_prev_hit && !i_item.last_record;
        end
    end

    // Best-core payload, read only while its flag is set
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_idle_core  <= n_idle_core;
            r_idle_cap   <= n_idle_cap;
            r_idle_lat   <= n_idle_lat;
            r_idle_small <= n_idle_small;
            r_busy_core  <= n_busy_core;
            r_busy_cap   <= n_busy_cap;
            r_busy_load  <= n_busy_load;
            r_busy_small <= n_busy_small;
        end
    end

endmodule

FILE: sv/rt_core_select_by_capacity.sv
// Top level of the real-time wake target selector: handshakes, pipeline
// registers and the enable register. Depends on rtcs_pkg, rtcs_fit, rtcs_track.
`timescale 1ns / 1ps

// Core records stream in one item per cycle unless o_in_stall holds them, in
// ascending core order; the record flagged last_record closes the run and
// yields one result item (found, target_core). Throughput is one record per
// clock while no closing record waits on a stalled output. A result passes
// from the input register, where the fit stage works through the 12 x 12 bit
// load-margin multiply, to the fit register, where the tracking stage updates
// the running bests and picks the target into the output register.
// Records that do not close a run keep flowing while a result waits on a
// stalled output. The enable register is written through the configuration
// channel, which is always ready; write it only while no run is in flight.
module rt_core_select_by_capacity (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rtcs_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rtcs_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    logic                r_enable;
    logic                r_s1_vld;
    rtcs_pkg::t_in_item  r_s1;
    logic                r_s2_vld;
    rtcs_pkg::t_in_item  r_s2;
    rtcs_pkg::t_fit      r_s2_fit;
    logic                r_out_vld;
    rtcs_pkg::t_out_item r_out;
    rtcs_pkg::t_fit      s1_fit;
    rtcs_pkg::t_out_item result;
    logic                out_free;
    logic                s2_go;
    logic                s2_free;
    logic                s1_free;

    // Stage advance: only a closing record needs the output slot
    always_comb begin
        out_free = !r_out_vld || !i_out_stall;
        s2_go    = r_s2_vld && (out_free || !r_s2.last_record);
        s2_free  = !r_s2_vld || s2_go;
        s1_free  = !r_s1_vld || s2_free;
    end

    assign o_in_stall  = !s1_free;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // Enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_enable <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in_valid) begin
            r_s1 <= i_in_item;
        end
    end

    rtcs_fit u_fit (
        .i_item (r_s1),
        .o_fit  (s1_fit)
    );

    // Fit stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_free) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_vld) begin
            r_s2     <= r_s1;
            r_s2_fit <= s1_fit;
        end
    end

    rtcs_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (s2_go),
        .i_item   (r_s2),
        .i_fit    (r_s2_fit),
        .i_enable (r_enable),
        .o_result (result)
    );

    // Output register: load on a closing record, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= s2_go && r_s2.last_record;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s2_go && r_s2.last_record) begin
            r_out <= result;
        end
    end

endmodule

FILE: sv/rtcs_checker.sv
// Port-level checks for the real-time wake target selector, bound to the
// top level. Depends on rtcs_pkg and rt_core_select_by_capacity.
`timescale 1ns / 1ps

module rtcs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input rtcs_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rtcs_pkg::t_out_item o_out_item,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic                i_cfg_data
);

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // No target reported without a find
    a_no_find_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> (o_out_item.target_core == '0))
        else $error("target set without a find");

    // Disabled selection never reports a target
    a_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && !i_cfg_data && !o_out_valid)
        |=> !(o_out_valid && o_out_item.found))
        else $error("target reported while disabled");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind rt_core_select_by_capacity rtcs_checker u_rtcs_checker (.*);

FILE: dv/rt_core_select_by_capacity_tb.sv
// Testbench for rt_core_select_by_capacity: directed core-selection runs from a
// stimulus table, then random runs under several idle/stall phases, scored against
// typed rows' table results or an in-bench predictor. Depends on rtcs_pkg and the block's RTL.
`timescale 1ns / 1ps

module rt_core_select_by_capacity_tb;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int SETTLE_WAIT  = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_GUARD  = 20000;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // Running bests of one selection
    typedef struct {
        bit                          idle_ok;
        bit [rtcs_pkg::CORE_W-1:0]   idle_core;
        bit [rtcs_pkg::LOAD_W-1:0]   idle_cap;
        bit [rtcs_pkg::LAT_W-1:0]    idle_lat;
        bit                          idle_is_small;
        bit                          busy_ok;
        bit [rtcs_pkg::CORE_W-1:0]   busy_core;
        bit [rtcs_pkg::LOAD_W-1:0]   busy_cap;
        bit [rtcs_pkg::UTIL_W-1:0]   busy_util;
        bit                          busy_is_small;
        bit                          prev_hit;
    } t_best_cores;

    // One directed row; want is used only when typed is set
    typedef struct {
        rtcs_pkg::t_in_item  rec;
        bit                  en;
        bit                  typed;
        rtcs_pkg::t_out_item want;
    } t_stim_row;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    rtcs_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_stall;
    rtcs_pkg::t_out_item out_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_data;

    t_best_cores         best;
    bit                  sel_enable;
    rtcs_pkg::t_out_item pending_targets[$];
    t_stim_row           directed_rows[$];
    t_idle_mode          idle_mode;
    int unsigned         hold_requests;
    int unsigned         records_sent;
    int unsigned         results_seen;
    int unsigned         input_stalls;
    int unsigned         mismatch_count;

    rt_core_select_by_capacity u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Selection predictor
    function automatic void clear_best();
        best = '{default: 0};
    endfunction

    // Fold one record into the running bests; return 1 with the target on a last record
    function automatic bit pick_target(input rtcs_pkg::t_in_item r,
                                       output rtcs_pkg::t_out_item res);
        bit [rtcs_pkg::UTIL_W-1:0] util;
        bit [rtcs_pkg::PROD_W-1:0] need;
        bit [rtcs_pkg::PROD_W-1:0] room;
        res  = '0;
        util = rtcs_pkg::UTIL_W'(r.core_load) + rtcs_pkg::UTIL_W'(r.task_load);
        need = rtcs_pkg::PROD_W'(util) * rtcs_pkg::PROD_W'(r.margin_up);
        room = rtcs_pkg::PROD_W'(r.core_capacity) << rtcs_pkg::CAP_SHIFT;
        if (int'(r.core_index) < rtcs_pkg::NUM_CORES) begin
            if (r.core_index == r.previous_core && r.in_candidates && r.core_idle &&
                r.small_core)
                best.prev_hit = 1'b1;
            if (r.in_candidates && r.eligible && need <= room) begin
                if (r.core_idle) begin
                    if (!best.idle_ok || r.core_capacity < best.idle_cap ||
                        (r.core_capacity == best.idle_cap && r.wake_latency < best.idle_lat)) begin
                        best.idle_ok       = 1'b1;
                        best.idle_core     = r.core_index;
                        best.idle_cap      = r.core_capacity;
                        best.idle_lat      = r.wake_latency;
                        best.idle_is_small = r.small_core;
                    end
                end else begin
                    if (!best.busy_ok || r.core_capacity < best.busy_cap ||
                        (r.core_capacity == best.busy_cap && util < best.busy_util)) begin
                        best.busy_ok       = 1'b1;
                        best.busy_core     = r.core_index;
                        best.busy_cap      = r.core_capacity;
                        best.busy_util     = util;
                        best.busy_is_small = r.small_core;
                    end
                end
            end
        end
        if (!r.last_record)
            return 1'b0;
        // Previous core first, then small idle, small busy, any idle, any busy
        res.found = 1'b1;
        if (best.prev_hit)
            res.target_core = r.previous_core;
        else if (best.idle_ok && best.idle_is_small)
            res.target_core = best.idle_core;
        else if (best.busy_ok && best.busy_is_small)
            res.target_core = best.busy_core;
        else if (best.idle_ok)
            res.target_core = best.idle_core;
        else if (best.busy_ok)
            res.target_core = best.busy_core;
        else
            res.found = 1'b0;
        if (!sel_enable || !res.found)
            res = '0;
        clear_best();
        return 1'b1;
    endfunction

    function automatic rtcs_pkg::t_in_item rec_of(input int core, input bit cand,
                                                  input bit elig, input bit idle,
                                                  input bit is_small, input int load,
                                                  input int cap, input int margin,
                                                  input int lat, input int tload,
                                                  input int prev, input bit last);
        rtcs_pkg::t_in_item r;
        r.core_index    = rtcs_pkg::CORE_W'(core);
        r.in_candidates = cand;
        r.eligible      = elig;
        r.core_idle     = idle;
        r.small_core    = is_small;
        r.core_load     = rtcs_pkg::LOAD_W'(load);
        r.core_capacity = rtcs_pkg::LOAD_W'(cap);
        r.margin_up     = rtcs_pkg::MARGIN_W'(margin);
        r.wake_latency  = rtcs_pkg::LAT_W'(lat);
        r.task_load     = rtcs_pkg::LOAD_W'(tload);
        r.previous_core = rtcs_pkg::CORE_W'(prev);
        r.last_record   = last;
        return r;
    endfunction

    function automatic void add_row(input bit en, input bit typed, input bit found,
                                    input int target, input rtcs_pkg::t_in_item rec);
        t_stim_row row;
        row.rec              = rec;
        row.en               = en;
        row.typed            = typed;
        row.want.found       = found;
        row.want.target_core = rtcs_pkg::CORE_W'(target);
        directed_rows.push_back(row);
    endfunction

    // Random record content, biased toward fits, ties and the capacity extremes
    function automatic rtcs_pkg::t_in_item random_record();
        rtcs_pkg::t_in_item        r;
        bit [rtcs_pkg::LOAD_W-1:0] caps[5] = '{11'd0, 11'd256, 11'd512, 11'd768, 11'd1024};
        bit [rtcs_pkg::LAT_W-1:0]  lats[4] = '{16'd0, 16'd10, 16'd100, 16'd65535};
        r.core_index    = rtcs_pkg::CORE_W'($urandom_range(rtcs_pkg::NUM_CORES - 1));
        r.in_candidates = $urandom_range(99) < 85;
        r.eligible      = $urandom_range(99) < 85;
        r.core_idle     = 1'($urandom_range(1));
        r.small_core    = 1'($urandom_range(1));
        r.core_load     = ($urandom_range(99) < 70)
                        ? rtcs_pkg::LOAD_W'($urandom_range(400))
                        : rtcs_pkg::LOAD_W'($urandom_range(1024));
        r.core_capacity = ($urandom_range(99) < 60) ? caps[$urandom_range(4)]
                                                    : rtcs_pkg::LOAD_W'($urandom_range(1024));
        r.margin_up     = ($urandom_range(99) < 70)
                        ? rtcs_pkg::MARGIN_W'($urandom_range(1300, 1024))
                        : rtcs_pkg::MARGIN_W'($urandom_range(4095));
        r.wake_latency  = ($urandom_range(1) == 1) ? lats[$urandom_range(3)]
                                                   : rtcs_pkg::LAT_W'($urandom_range(65535));
        r.task_load     = ($urandom_range(99) < 70)
                        ? rtcs_pkg::LOAD_W'($urandom_range(300))
                        : rtcs_pkg::LOAD_W'($urandom_range(1024));
        r.previous_core = rtcs_pkg::CORE_W'($urandom_range(rtcs_pkg::NUM_CORES - 1));
        r.last_record   = 1'b0;
        return r;
    endfunction

    function automatic bit sender_waits();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99) < 79;
            IDLE_BOTH: return $urandom_range(99) < 12;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic void report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, what);
    endfunction

    // Offer one record until accepted; called and returning just after a falling edge
    task automatic send_record(input rtcs_pkg::t_in_item rec, input bit typed,
                               input rtcs_pkg::t_out_item want);
        rtcs_pkg::t_out_item res;
        while (sender_waits()) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= rec;
        do @(posedge clk); while (in_stall);
        if (pick_target(rec, res))
            pending_targets.push_back(typed ? want : res);
        records_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline empty
    task automatic settle();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending_targets.size() != 0 && guard < DRAIN_GUARD) begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic write_enable(input bit value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sel_enable = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Switch idle phase off the falling edge the receiver reacts on
    task automatic enter_mode(input t_idle_mode mode, input bit hold);
        in_valid <= 1'b0;
        @(posedge clk);
        idle_mode = mode;
        if (hold)
            hold_requests++;
        @(negedge clk);
    endtask

    // One selection run: mostly ascending cores with shared task fields, some noise
    task automatic send_random_run(input int max_len);
        int                        n;
        int                        first;
        bit                        tidy;
        bit [rtcs_pkg::LOAD_W-1:0] tload;
        bit [rtcs_pkg::CORE_W-1:0] prev;
        rtcs_pkg::t_in_item        rec;
        rtcs_pkg::t_out_item       none;
        none  = '0;
        n     = $urandom_range(max_len, 1);
        tidy  = $urandom_range(99) < 85;
        first = $urandom_range(rtcs_pkg::NUM_CORES - n);
        tload = random_record().task_load;
        prev  = ($urandom_range(1) == 1)
              ? rtcs_pkg::CORE_W'(first + $urandom_range(n - 1))
              : rtcs_pkg::CORE_W'($urandom_range(rtcs_pkg::NUM_CORES - 1));
        for (int i = 0; i < n; i++) begin
            rec = random_record();
            if (tidy) begin
                rec.core_index    = rtcs_pkg::CORE_W'(first + i);
                rec.task_load     = tload;
                rec.previous_core = prev;
                // Plant a previous-core hit now and then
                if (rec.core_index == prev && $urandom_range(99) < 30) begin
                    rec.in_candidates = 1'b1;
                    rec.core_idle     = 1'b1;
                    rec.small_core    = 1'b1;
                end
            end
            rec.last_record = (i == n - 1);
            send_record(rec, 1'b0, none);
        end
    endtask

    task automatic random_phase(input t_idle_mode mode, input bit en, input int items);
        int unsigned start;
        if (en != sel_enable)
            write_enable(en);
        enter_mode(mode, 1'b0);
        start = records_sent;
        while (records_sent - start < items)
            send_random_run(8);
    endtask

    // Receiver: random stalls per phase, plus a long hold-off on request
    initial begin
        int          hold_left;
        int unsigned hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (idle_mode)
                    IDLE_RECV: out_stall <= $urandom_range(99) < 79;
                    IDLE_BOTH: out_stall <= $urandom_range(99) < 12;
                    default:   out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Score every accepted result against the oldest expectation
    always @(posedge clk) begin
        rtcs_pkg::t_out_item want;
        if (rst_n && in_valid && in_stall)
            input_stalls++;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_targets.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0d core=%0d",
                                          out_item.found, out_item.target_core));
            end else begin
                want = pending_targets.pop_front();
                if (out_item.found !== want.found || out_item.target_core !== want.target_core)
                    report_mismatch($sformatf(
                        "mismatch: expected found=%0d core=%0d, got found=%0d core=%0d",
                        want.found, want.target_core, out_item.found, out_item.target_core));
            end
        end
    end

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        idle_mode      = IDLE_NONE;
        hold_requests  = 0;
        records_sent   = 0;
        results_seen   = 0;
        input_stalls   = 0;
        mismatch_count = 0;
        sel_enable     = 1'b1;
        clear_best();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_enable(1'b1);

        // Directed runs: core, cand, elig, idle, small, load, cap, margin, lat, task, prev, last
        add_row(1, 1, 0, 0, rec_of(0, 0, 1, 1, 1, 0, 1024, 1024, 0, 0, 4, 1));
        add_row(1, 1, 1, 3, rec_of(3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 5, 1));
        // fit exactly on the boundary, then one margin step over it
        add_row(1, 1, 1, 7, rec_of(7, 1, 1, 0, 1, 512, 1024, 1024, 65535, 512, 0, 1));
        add_row(1, 1, 0, 0, rec_of(6, 1, 1, 1, 1, 512, 1024, 1025, 0, 512, 0, 1));
        // previous-core hit wins although ineligible and far from fitting
        add_row(1, 1, 1, 7, rec_of(7, 1, 0, 1, 1, 1024, 1024, 4095, 65535, 1024, 7, 1));
        add_row(1, 1, 0, 0, rec_of(5, 1, 1, 1, 1, 1024, 1024, 4095, 65535, 1024, 2, 1));
        // small idle beats big idle and small busy
        add_row(1, 0, 0, 0, rec_of(0, 1, 1, 1, 0, 100, 1024, 1024, 50, 100, 6, 0));
        add_row(1, 0, 0, 0, rec_of(1, 1, 1, 1, 1, 100, 512, 1024, 100, 100, 6, 0));
        add_row(1, 0, 0, 0, rec_of(2, 1, 1, 0, 1, 100, 256, 1024, 0, 100, 6, 1));
        // idle capacity tie: equal latency keeps the earlier, lower latency replaces
        add_row(1, 0, 0, 0, rec_of(2, 1, 1, 1, 1, 0, 512, 1024, 200, 0, 0, 0));
        add_row(1, 0, 0, 0, rec_of(3, 1, 1, 1, 1, 0, 512, 1024, 200, 0, 0, 0));
        add_row(1, 0, 0, 0, rec_of(4, 1, 1, 1, 1, 0, 512, 1024, 199, 0, 0, 1));
        // small busy beats big idle; busy capacity tie goes to lower load
        add_row(1, 0, 0, 0, rec_of(0, 1, 1, 1, 0, 0, 768, 1024, 0, 10, 7, 0));
        add_row(1, 0, 0, 0, rec_of(1, 1, 1, 0, 1, 300, 512, 1024, 0, 10, 7, 0));
        add_row(1, 0, 0, 0, rec_of(2, 1, 1, 0, 1, 200, 512, 1024, 0, 10, 7, 1));
        // ineligible skipped, repeated core index, previous core varying per record
        add_row(1, 0, 0, 0, rec_of(4, 1, 0, 1, 1, 0, 256, 1024, 0, 0, 1, 0));
        add_row(1, 0, 0, 0, rec_of(4, 1, 1, 0, 0, 0, 1024, 1024, 0, 0, 3, 0));
        add_row(1, 0, 0, 0, rec_of(4, 1, 1, 1, 0, 0, 1024, 1024, 0, 0, 4, 1));
        // early hit, target taken from the previous core of the last record
        add_row(1, 0, 0, 0, rec_of(1, 1, 1, 1, 1, 0, 1024, 1024, 0, 0, 1, 0));
        add_row(1, 0, 0, 0, rec_of(2, 1, 1, 0, 0, 0, 1024, 1024, 0, 0, 5, 1));
        // selection disabled: no target is ever reported
        add_row(0, 1, 0, 0, rec_of(1, 1, 1, 1, 1, 0, 256, 1024, 0, 0, 1, 1));
        add_row(0, 0, 0, 0, rec_of(0, 1, 1, 0, 1, 10, 512, 1024, 0, 10, 3, 0));
        add_row(0, 1, 0, 0, rec_of(3, 1, 1, 1, 0, 10, 1024, 1024, 0, 10, 6, 1));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].en != sel_enable)
                write_enable(directed_rows[i].en);
            send_record(directed_rows[i].rec, directed_rows[i].typed, directed_rows[i].want);
        end

        random_phase(IDLE_NONE, 1'b1, 100);
        random_phase(IDLE_SEND, 1'b1, 90);
        random_phase(IDLE_RECV, 1'b0, 50);
        random_phase(IDLE_RECV, 1'b1, 90);
        random_phase(IDLE_BOTH, 1'b1, 90);

        // Hold the output off while short runs keep coming, so the input backs up
        enter_mode(IDLE_NONE, 1'b1);
        begin
            int unsigned start;
            start = records_sent;
            while (records_sent - start < 48)
                send_random_run(2);
        end

        settle();
        while (pending_targets.size() != 0) begin
            rtcs_pkg::t_out_item lost;
            lost = pending_targets.pop_front();
            report_mismatch($sformatf("missing result found=%0d core=%0d",
                                      lost.found, lost.target_core));
        end

        $display("Sent %0d core records, checked %0d selection results, enable 0 and 1",
                 records_sent, results_seen);
        $display("Idle phases none/sender/receiver/both plus a hold-off; input stalled %0d cycles",
                 input_stalls);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("timeout after %0d records", records_sent);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
